// ===== rtl/core/blca_pkg.sv =====
// ----------------------------------------------------------------------------
// blca_pkg
// Shared types and codes of the binary-lifting ancestor engine: item kinds,
// controller states, datapath operations and the command/status bundles.
// ----------------------------------------------------------------------------
package blca_pkg;

	localparam int FIELD_W = 10;

	typedef logic [FIELD_W-1:0] node_t;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_BUILD = 2'd1,
		KIND_LCA   = 2'd2,
		KIND_LIFT  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEPTH,
		ST_SETUP,
		ST_LIFT_RD,
		ST_LIFT_WB,
		ST_POST,
		ST_DESC_RD,
		ST_DESC_WB,
		ST_FIN_RD,
		ST_FIN_WB,
		ST_ANS_RD,
		ST_ANS_WB,
		ST_B_RD1,
		ST_B_RD2,
		ST_B_WR
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_CAPTURE,
		DP_DEPTH_RD,
		DP_SETUP,
		DP_LIFT_RD,
		DP_LIFT_WB,
		DP_LIFT_ADV,
		DP_DESC_INIT,
		DP_DESC_RD,
		DP_DESC_WB,
		DP_FIN_RD,
		DP_FIN_WB,
		DP_ANS_RD,
		DP_EMIT,
		DP_BUILD_INIT
	} dp_op_t;

	typedef enum logic [1:0] {
		BP_NONE,
		BP_RD1,
		BP_RD2,
		BP_WR
	} bld_op_t;

	typedef struct packed {
		dp_op_t  op;
		bld_op_t bop;
		logic    lca;
	} cmd_t;

	typedef struct packed {
		logic lift_bit;
		logic lift_end;
		logic same;
		logic shallow;
		logic lvl_zero;
		logic node_last;
		logic level_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/blca_ifs.sv =====
// ----------------------------------------------------------------------------
// blca channel interfaces
// Valid/ready channels for request items and answer items.
// ----------------------------------------------------------------------------
interface blca_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          kind;
	blca_pkg::node_t     node_a;
	blca_pkg::node_t     node_b;
	blca_pkg::node_t     parent_node;
	blca_pkg::node_t     node_level;

	modport source (output valid, kind, node_a, node_b, parent_node, node_level,
		input ready);
	modport sink (input valid, kind, node_a, node_b, parent_node, node_level,
		output ready);
endinterface

interface blca_out_if;
	logic                valid;
	logic                ready;
	blca_pkg::node_t     answer_node;
	blca_pkg::node_t     answer_level;

	modport source (output valid, answer_node, answer_level, input ready);
	modport sink (input valid, answer_node, answer_level, output ready);
endinterface

// ===== rtl/core/binary_lifting_lca.sv =====
// ----------------------------------------------------------------------------
// binary_lifting_lca
// Rooted-tree ancestor engine: loads parents and depths, builds the
// binary-lifting jump table, answers lowest common ancestor and
// ancestor-at-depth queries.
// ----------------------------------------------------------------------------
//  channel   dir  fields                                       item
//  in_ch     in   kind node_a node_b parent_node node_level    request
//  out_ch    out  answer_node answer_level                     answer (queries only)
//
//  a load item writes both memories as it is taken; a build walks levels 1 to
//  LEVELS-1 over nodes 1 to N-1, N = min(MAX_NODES, 1024), two reads, one write each
//  a query reads and writes back per set gap bit, only advances per clear bit below
//  the highest, reads and writes back per descent level, bound by the registered read
//  the answer waits in an output register while a new item is taken; a finished
//  query stalls only while the previous answer is unread; reset clears control only
module binary_lifting_lca #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	blca_in_if.sink    in_ch,
	blca_out_if.source out_ch
);

	blca_pkg::cmd_t cmd;
	blca_pkg::sts_t sts;

	blca_ctrl #(
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	blca_datapath #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.node_a       (in_ch.node_a),
		.node_b       (in_ch.node_b),
		.parent_node  (in_ch.parent_node),
		.node_level   (in_ch.node_level),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.answer_node  (out_ch.answer_node),
		.answer_level (out_ch.answer_level)
	);

endmodule

// ===== rtl/core/blca_ctrl.sv =====
// ----------------------------------------------------------------------------
// blca_ctrl
// Sequencer of the ancestor engine: takes items, steps loads, table builds
// and queries through the datapath by command, reading back its status.
// ----------------------------------------------------------------------------
module blca_ctrl #(
	parameter int LEVELS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_kind,
	output logic             in_ready,
	output blca_pkg::cmd_t   cmd,
	input  blca_pkg::sts_t   sts
);

	blca_pkg::state_t state_q, state_nx;
	logic lca_q;
	logic lca_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blca_pkg::ST_IDLE;
			lca_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			lca_q   <= lca_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		lca_nx   = lca_q;
		in_ready = 1'b0;
		cmd.op   = blca_pkg::DP_NOP;
		cmd.bop  = blca_pkg::BP_NONE;
		cmd.lca  = lca_q;
		unique case (state_q)
			blca_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_kind)
						blca_pkg::KIND_LOAD: begin
							cmd.op = blca_pkg::DP_LOAD;
						end
						blca_pkg::KIND_BUILD: begin
							if (LEVELS > 1) begin
								cmd.op   = blca_pkg::DP_BUILD_INIT;
								state_nx = blca_pkg::ST_B_RD1;
							end
						end
						default: begin
							cmd.op   = blca_pkg::DP_CAPTURE;
							lca_nx   = (in_kind == blca_pkg::KIND_LCA);
							state_nx = blca_pkg::ST_DEPTH;
						end
					endcase
				end
			end
			blca_pkg::ST_DEPTH: begin
				cmd.op   = blca_pkg::DP_DEPTH_RD;
				state_nx = blca_pkg::ST_SETUP;
			end
			blca_pkg::ST_SETUP: begin
				cmd.op = blca_pkg::DP_SETUP;
				// target deeper than the node: the node itself is the answer
				if (!lca_q && sts.shallow) begin
					state_nx = blca_pkg::ST_ANS_RD;
				end else begin
					state_nx = blca_pkg::ST_LIFT_RD;
				end
			end
			blca_pkg::ST_LIFT_RD: begin
				if (sts.lift_bit) begin
					cmd.op   = blca_pkg::DP_LIFT_RD;
					state_nx = blca_pkg::ST_LIFT_WB;
				end else begin
					cmd.op   = blca_pkg::DP_LIFT_ADV;
					state_nx = sts.lift_end ? blca_pkg::ST_POST : blca_pkg::ST_LIFT_RD;
				end
			end
			blca_pkg::ST_LIFT_WB: begin
				cmd.op   = blca_pkg::DP_LIFT_WB;
				state_nx = sts.lift_end ? blca_pkg::ST_POST : blca_pkg::ST_LIFT_RD;
			end
			blca_pkg::ST_POST: begin
				if (!lca_q || sts.same) begin
					state_nx = blca_pkg::ST_ANS_RD;
				end else begin
					cmd.op   = blca_pkg::DP_DESC_INIT;
					state_nx = blca_pkg::ST_DESC_RD;
				end
			end
			blca_pkg::ST_DESC_RD: begin
				cmd.op   = blca_pkg::DP_DESC_RD;
				state_nx = blca_pkg::ST_DESC_WB;
			end
			blca_pkg::ST_DESC_WB: begin
				cmd.op   = blca_pkg::DP_DESC_WB;
				state_nx = sts.lvl_zero ? blca_pkg::ST_FIN_RD : blca_pkg::ST_DESC_RD;
			end
			blca_pkg::ST_FIN_RD: begin
				cmd.op   = blca_pkg::DP_FIN_RD;
				state_nx = blca_pkg::ST_FIN_WB;
			end
			blca_pkg::ST_FIN_WB: begin
				cmd.op   = blca_pkg::DP_FIN_WB;
				state_nx = blca_pkg::ST_ANS_RD;
			end
			blca_pkg::ST_ANS_RD: begin
				cmd.op   = blca_pkg::DP_ANS_RD;
				state_nx = blca_pkg::ST_ANS_WB;
			end
			blca_pkg::ST_ANS_WB: begin
				// hold the answer until the output register frees up
				if (sts.out_free) begin
					cmd.op   = blca_pkg::DP_EMIT;
					state_nx = blca_pkg::ST_IDLE;
				end
			end
			blca_pkg::ST_B_RD1: begin
				cmd.bop  = blca_pkg::BP_RD1;
				state_nx = blca_pkg::ST_B_RD2;
			end
			blca_pkg::ST_B_RD2: begin
				cmd.bop  = blca_pkg::BP_RD2;
				state_nx = blca_pkg::ST_B_WR;
			end
			blca_pkg::ST_B_WR: begin
				cmd.bop = blca_pkg::BP_WR;
				if (sts.node_last && sts.level_last) begin
					state_nx = blca_pkg::ST_IDLE;
				end else begin
					state_nx = blca_pkg::ST_B_RD1;
				end
			end
			default: begin
				state_nx = blca_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/blca_datapath.sv =====
// ----------------------------------------------------------------------------
// blca_datapath
// Jump table and depth memories, query node registers, lift and level
// counters, build sweep counters and the answer output register.
// ----------------------------------------------------------------------------
module blca_datapath #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  blca_pkg::cmd_t   cmd,
	output blca_pkg::sts_t   sts,
	input  blca_pkg::node_t  node_a,
	input  blca_pkg::node_t  node_b,
	input  blca_pkg::node_t  parent_node,
	input  blca_pkg::node_t  node_level,
	input  logic             out_ready,
	output logic             out_valid,
	output blca_pkg::node_t  answer_node,
	output blca_pkg::node_t  answer_level
);

	localparam int FW         = blca_pkg::FIELD_W;
	// node numbers are FW bits wide, so no higher entry is ever addressed
	localparam int NODES_USED = (MAX_NODES < (1 << FW)) ? MAX_NODES : (1 << FW);
	localparam int NW         = $clog2(NODES_USED);
	localparam int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	function automatic blca_pkg::node_t nok(input blca_pkg::node_t n);
		return (32'(n) < MAX_NODES) ? n : '0;
	endfunction

	function automatic logic [NW-1:0] idx(input blca_pkg::node_t n);
		return NW'(n);
	endfunction

	blca_pkg::node_t jump_mem [0:LEVELS-1][0:NODES_USED-1];
	blca_pkg::node_t depth_mem [0:NODES_USED-1];

	blca_pkg::node_t u_q, v_q, gap_q;
	logic [LW-1:0]   lvl_q;
	logic [NW-1:0]   i_q;
	blca_pkg::node_t jra_q, jrb_q, dra_q, drb_q;
	logic            jza_q, jzb_q, dza_q, dzb_q;
	logic            out_valid_q;
	blca_pkg::node_t ans_node_q, ans_level_q;

	blca_pkg::node_t up_a, up_b, depth_u, depth_v;
	blca_pkg::node_t ra_node;
	logic [LW-1:0]   ra_lvl, lvl_dec;
	logic            ra_en, rb_en, load_en, emit;

	// node 0 is the sentinel: its own parent at depth 0, never stored
	assign up_a    = jza_q ? '0 : nok(jra_q);
	assign up_b    = jzb_q ? '0 : nok(jrb_q);
	assign depth_u = dza_q ? '0 : dra_q;
	assign depth_v = dzb_q ? '0 : drb_q;
	assign lvl_dec = lvl_q - LW'(1);
	assign load_en = (cmd.op == blca_pkg::DP_LOAD) && (node_a != '0)
		&& (32'(node_a) < MAX_NODES);
	assign rb_en   = (cmd.op == blca_pkg::DP_DESC_RD);
	assign emit    = (cmd.op == blca_pkg::DP_EMIT);

	always_comb begin
		ra_en   = 1'b0;
		ra_lvl  = lvl_q;
		ra_node = u_q;
		unique case (cmd.op) inside
			blca_pkg::DP_LIFT_RD, blca_pkg::DP_DESC_RD: begin
				ra_en = 1'b1;
			end
			blca_pkg::DP_FIN_RD: begin
				ra_en  = 1'b1;
				ra_lvl = '0;
			end
			default: begin
			end
		endcase
		unique case (cmd.bop)
			blca_pkg::BP_RD1: begin
				ra_en   = 1'b1;
				ra_lvl  = lvl_dec;
				ra_node = blca_pkg::node_t'(i_q);
			end
			blca_pkg::BP_RD2: begin
				ra_en   = 1'b1;
				ra_lvl  = lvl_dec;
				ra_node = up_a;
			end
			default: begin
			end
		endcase
	end

	// jump table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (load_en) begin
			jump_mem[0][idx(node_a)] <= parent_node;
		end else if (cmd.bop == blca_pkg::BP_WR) begin
			jump_mem[lvl_q][idx(blca_pkg::node_t'(i_q))] <= up_a;
		end
		if (ra_en) begin
			jra_q <= jump_mem[ra_lvl][idx(ra_node)];
			jza_q <= (ra_node == '0);
		end
		if (rb_en) begin
			jrb_q <= jump_mem[lvl_q][idx(v_q)];
			jzb_q <= (v_q == '0);
		end
	end

	// depth store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (load_en) begin
			depth_mem[idx(node_a)] <= node_level;
		end
		if ((cmd.op == blca_pkg::DP_DEPTH_RD) || (cmd.op == blca_pkg::DP_ANS_RD)) begin
			dra_q <= depth_mem[idx(u_q)];
			dza_q <= (u_q == '0);
		end
		if (cmd.op == blca_pkg::DP_DEPTH_RD) begin
			drb_q <= depth_mem[idx(v_q)];
			dzb_q <= (v_q == '0);
		end
	end

	// query node pair
	always_ff @(posedge clk) begin
		unique case (cmd.op) inside
			blca_pkg::DP_CAPTURE: begin
				u_q <= nok(node_a);
				v_q <= nok(node_b);
			end
			blca_pkg::DP_SETUP: begin
				// keep the deeper node in u
				if (cmd.lca && sts.shallow) begin
					u_q <= v_q;
					v_q <= u_q;
				end
			end
			blca_pkg::DP_LIFT_WB, blca_pkg::DP_FIN_WB: begin
				u_q <= up_a;
			end
			blca_pkg::DP_DESC_WB: begin
				if (up_a != up_b) begin
					u_q <= up_a;
					v_q <= up_b;
				end
			end
			default: begin
			end
		endcase
	end

	// lift gap, level and build node counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
			lvl_q <= '0;
			i_q   <= '0;
		end else begin
			unique case (cmd.op) inside
				blca_pkg::DP_SETUP: begin
					gap_q <= (cmd.lca && sts.shallow) ? (depth_v - depth_u)
						: (depth_u - depth_v);
					lvl_q <= '0;
				end
				blca_pkg::DP_LIFT_ADV, blca_pkg::DP_LIFT_WB: begin
					gap_q <= gap_q >> 1;
					lvl_q <= lvl_q + LW'(1);
				end
				blca_pkg::DP_DESC_INIT: begin
					lvl_q <= LW'(LEVELS - 1);
				end
				blca_pkg::DP_DESC_WB: begin
					if (lvl_q != '0) begin
						lvl_q <= lvl_dec;
					end
				end
				blca_pkg::DP_BUILD_INIT: begin
					lvl_q <= LW'(1);
					i_q   <= NW'(1);
				end
				default: begin
				end
			endcase
			if (cmd.bop == blca_pkg::BP_WR) begin
				if (sts.node_last) begin
					i_q   <= NW'(1);
					lvl_q <= lvl_q + LW'(1);
				end else begin
					i_q <= i_q + NW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ans_node_q  <= u_q;
			ans_level_q <= depth_u;
		end
	end

	assign sts.lift_bit   = gap_q[0];
	assign sts.lift_end   = (lvl_q == LW'(LEVELS - 1)) || (gap_q[FW-1:1] == '0);
	assign sts.same       = (u_q == v_q);
	assign sts.shallow    = (depth_u < depth_v);
	assign sts.lvl_zero   = (lvl_q == '0);
	assign sts.node_last  = (i_q == NW'(NODES_USED - 1));
	assign sts.level_last = (lvl_q == LW'(LEVELS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign answer_node  = ans_node_q;
	assign answer_level = ans_level_q;

endmodule

// ===== rtl/core/blca_checker.sv =====
// ----------------------------------------------------------------------------
// blca_checker
// Port-level checks of the ancestor engine, bound to the top level.
// ----------------------------------------------------------------------------
module blca_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [1:0]       in_kind,
	input logic             out_valid,
	input logic             out_ready,
	input blca_pkg::node_t  answer_node,
	input blca_pkg::node_t  answer_level
);

	logic       in_acc, out_acc, query_acc;
	logic [1:0] pend_q;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign query_acc = in_acc && ((in_kind == blca_pkg::KIND_LCA)
		|| (in_kind == blca_pkg::KIND_LIFT));

	// queries taken and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(query_acc) - 2'(out_acc);
		end
	end

	a_no_extra_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pend_q != 2'd0))
		else $error("answer item without a pending query");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_kind == blca_pkg::KIND_LOAD)) |=> in_ready)
		else $error("load item did not complete in one cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !in_ready)
		else $error("new item taken right after a query");

	a_sentinel_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (answer_node == '0)) |-> (answer_level == '0))
		else $error("sentinel answer with nonzero depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(answer_node)
			&& $stable(answer_level)))
		else $error("stalled answer changed");

endmodule

bind binary_lifting_lca blca_checker u_blca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_kind      (in_ch.kind),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.answer_node  (out_ch.answer_node),
	.answer_level (out_ch.answer_level)
);

// ===== sim/binary_lifting_lca_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_lifting_lca_tb
// Loads a random forest into the ancestor engine, builds the jump table and
// checks lca and ancestor-at-depth answers against a local predictor. Later
// phases re-parent nodes, load inconsistent depths and rebuild, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module binary_lifting_lca_tb;

	localparam int NODES          = 1024;
	localparam int LEVELS         = 10;
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 250000;

	typedef struct packed {
		blca_pkg::kind_t kind;
		blca_pkg::node_t node_a;
		blca_pkg::node_t node_b;
		blca_pkg::node_t parent_node;
		blca_pkg::node_t node_level;
	} request_t;

	typedef struct packed {
		blca_pkg::node_t anc_node;
		blca_pkg::node_t anc_level;
	} answer_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	blca_in_if  req_ch ();
	blca_out_if ans_ch ();

	binary_lifting_lca u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (ans_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// driven copies of the channel inputs
	logic     tx_valid = 1'b0;
	request_t tx_req   = '0;
	logic     rx_ready = 1'b0;

	assign req_ch.valid       = tx_valid;
	assign req_ch.kind        = tx_req.kind;
	assign req_ch.node_a      = tx_req.node_a;
	assign req_ch.node_b      = tx_req.node_b;
	assign req_ch.parent_node = tx_req.parent_node;
	assign req_ch.node_level  = tx_req.node_level;
	assign ans_ch.ready       = rx_ready;

	request_t    req_q[$];
	answer_t     answer_q[$];
	int unsigned tx_pct      = 23;
	int unsigned rx_pct      = 74;
	int unsigned holds_asked = 0;
	int unsigned holds_done  = 0;
	int unsigned hold_left   = 0;
	int unsigned mismatches  = 0;
	int unsigned answers_seen = 0;
	int unsigned quiet_cycles = 0;
	answer_t     want_ans;

	// predicted engine state
	blca_pkg::node_t jump_tab [LEVELS][NODES];
	blca_pkg::node_t depth_tab [NODES];

	// tree as the stimulus sees it, used to pick loads and interesting queries
	blca_pkg::node_t tree_par [NODES];
	blca_pkg::node_t tree_dep [NODES];

	function automatic blca_pkg::node_t rand_node();
		return blca_pkg::node_t'($urandom);
	endfunction

	function automatic blca_pkg::node_t pick_node();
		return blca_pkg::node_t'($urandom_range(NODES - 1, 1));
	endfunction

	function automatic blca_pkg::node_t lift_by(blca_pkg::node_t n, blca_pkg::node_t gap);
		blca_pkg::node_t cur;
		cur = n;
		for (int j = 0; j < LEVELS; j++)
			if (gap[j])
				cur = jump_tab[j][cur];
		return cur;
	endfunction

	function automatic blca_pkg::node_t common_ancestor(blca_pkg::node_t a,
			blca_pkg::node_t b);
		blca_pkg::node_t u, v, pu, pv;
		if (depth_tab[a] < depth_tab[b]) begin
			u = b;
			v = a;
		end else begin
			u = a;
			v = b;
		end
		u = lift_by(u, depth_tab[u] - depth_tab[v]);
		if (u == v)
			return u;
		for (int j = LEVELS - 1; j >= 0; j--) begin
			pu = jump_tab[j][u];
			pv = jump_tab[j][v];
			if (pu != pv) begin
				u = pu;
				v = pv;
			end
		end
		return jump_tab[0][u];
	endfunction

	function automatic blca_pkg::node_t ancestor_at_depth(blca_pkg::node_t a,
			blca_pkg::node_t target);
		if (depth_tab[a] < depth_tab[target])
			return a;
		return lift_by(a, depth_tab[a] - depth_tab[target]);
	endfunction

	function automatic void apply_request(request_t r);
		answer_t ans;
		case (r.kind)
			blca_pkg::KIND_LOAD: begin
				// the sentinel never changes
				if (r.node_a != '0) begin
					jump_tab[0][r.node_a] = r.parent_node;
					depth_tab[r.node_a]   = r.node_level;
				end
			end
			blca_pkg::KIND_BUILD: begin
				for (int j = 1; j < LEVELS; j++)
					for (int i = 1; i < NODES; i++)
						jump_tab[j][i] = jump_tab[j-1][jump_tab[j-1][i]];
			end
			default: begin
				if (r.kind == blca_pkg::KIND_LCA)
					ans.anc_node = common_ancestor(r.node_a, r.node_b);
				else
					ans.anc_node = ancestor_at_depth(r.node_a, r.node_b);
				ans.anc_level = depth_tab[ans.anc_node];
				answer_q = {answer_q, ans};
			end
		endcase
	endfunction

	function automatic blca_pkg::node_t walk_up(blca_pkg::node_t n, int unsigned steps);
		blca_pkg::node_t cur;
		cur = n;
		for (int unsigned s = 0; s < steps; s++)
			cur = tree_par[cur];
		return cur;
	endfunction

	function automatic blca_pkg::node_t deep_node();
		blca_pkg::node_t best, cand;
		best = pick_node();
		repeat (8) begin
			cand = pick_node();
			if (tree_dep[cand] > tree_dep[best])
				best = cand;
		end
		return best;
	endfunction

	function automatic request_t random_query();
		request_t        q;
		int unsigned     r;
		blca_pkg::node_t a, b, t;
		q.kind        = $urandom_range(1) ? blca_pkg::KIND_LIFT : blca_pkg::KIND_LCA;
		q.parent_node = rand_node();
		q.node_level  = rand_node();
		a = pick_node();
		b = pick_node();
		r = $urandom_range(99);
		if (r < 30) begin
			// unrelated pair
		end else if (r < 55) begin
			b = walk_up(a, $urandom_range(tree_dep[a]));
		end else if (r < 70) begin
			a = deep_node();
			if (r[0])
				b = walk_up(a, $urandom_range(tree_dep[a]));
		end else if (r < 78) begin
			b = a;
		end else if (r < 86) begin
			if (r[0])
				a = '0;
			else
				b = '0;
		end else if (tree_dep[a] > tree_dep[b]) begin
			// target deeper than the node
			t = a;
			a = b;
			b = t;
		end
		q.node_a = a;
		q.node_b = b;
		return q;
	endfunction

	task automatic send(blca_pkg::kind_t k, blca_pkg::node_t a, blca_pkg::node_t b,
			blca_pkg::node_t p, blca_pkg::node_t l);
		request_t r;
		r.kind        = k;
		r.node_a      = a;
		r.node_b      = b;
		r.parent_node = p;
		r.node_level  = l;
		req_q = {req_q, r};
	endtask

	task automatic send_queries(int unsigned count);
		repeat (count)
			req_q = {req_q, random_query()};
	endtask

	// move nodes under another parent at the same depth, keeping the forest sound
	task automatic reparent(int unsigned count);
		blca_pkg::node_t x, y, p;
		bit              found;
		repeat (count) begin
			x = pick_node();
			found = 1'b0;
			if (tree_dep[x] != '0) begin
				repeat (32) begin
					y = pick_node();
					if (!found && tree_dep[y] >= tree_dep[x] - 1) begin
						p = walk_up(y, tree_dep[y] - (tree_dep[x] - 1));
						found = 1'b1;
					end
				end
			end
			if (found) begin
				tree_par[x] = p;
				send(blca_pkg::KIND_LOAD, x, rand_node(), p, tree_dep[x]);
			end
		end
	endtask

	task automatic noise_loads(int unsigned count);
		blca_pkg::node_t x, p, l;
		repeat (count) begin
			x = ($urandom_range(9) == 0) ? '0 : pick_node();
			p = rand_node();
			l = rand_node();
			if (x != '0) begin
				tree_par[x] = p;
				tree_dep[x] = l;
			end
			send(blca_pkg::KIND_LOAD, x, rand_node(), p, l);
		end
	endtask

	task automatic send_build();
		send(blca_pkg::KIND_BUILD, rand_node(), rand_node(), rand_node(), rand_node());
	endtask

	task automatic drain();
		while (req_q.size() != 0 || tx_valid || answer_q.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_valid <= 1'b0;
		end else begin
			if (tx_valid && req_ch.ready) begin
				apply_request(tx_req);
				void'(req_q.pop_front());
			end
			if (tx_valid && !req_ch.ready) begin
				// item stays on the channel until taken
			end else if (req_q.size() != 0 && $urandom_range(99) >= tx_pct) begin
				tx_valid <= 1'b1;
				tx_req   <= req_q[0];
			end else begin
				tx_valid <= 1'b0;
			end
		end
	end

	// answer monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready   <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
		end else begin
			if (ans_ch.valid && rx_ready) begin
				answers_seen++;
				if (answer_q.size() == 0) begin
					note_mismatch($sformatf("answer %0d unexpected: node %0d level %0d",
						answers_seen, ans_ch.answer_node, ans_ch.answer_level));
				end else begin
					want_ans = answer_q.pop_front();
					if (ans_ch.answer_node !== want_ans.anc_node ||
							ans_ch.answer_level !== want_ans.anc_level)
						note_mismatch($sformatf(
							"answer %0d: expected node %0d level %0d, got node %0d level %0d",
							answers_seen, want_ans.anc_node, want_ans.anc_level,
							ans_ch.answer_node, ans_ch.answer_level));
				end
			end
			if (holds_done != holds_asked) begin
				holds_done <= holds_asked;
				hold_left  <= HOLD_CYCLES;
				rx_ready   <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rx_ready  <= 1'b0;
			end else begin
				rx_ready <= ($urandom_range(99) >= rx_pct);
			end
		end
	end

	// a build keeps both channels quiet, and the watchdog limit covers a whole build
	always @(posedge clk) begin
		if (!arst_n || (tx_valid && req_ch.ready) || (ans_ch.valid && rx_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stim
		blca_pkg::node_t order [NODES];
		blca_pkg::node_t tmp, deep, r;
		int unsigned     k, pick;

		foreach (jump_tab[j, i])
			jump_tab[j][i] = '0;
		foreach (depth_tab[i])
			depth_tab[i] = '0;

		// random forest: mostly long chains, a few extra roots
		tree_par[0] = '0;
		tree_dep[0] = '0;
		deep = blca_pkg::node_t'(1);
		for (int i = 1; i < NODES; i++) begin
			pick = $urandom_range(99);
			if (i == 1 || pick < 2) begin
				tree_par[i] = '0;
				tree_dep[i] = '0;
			end else begin
				tree_par[i] = (pick < 78) ? blca_pkg::node_t'(i - 1)
					: blca_pkg::node_t'($urandom_range(i - 1, 1));
				tree_dep[i] = tree_dep[tree_par[i]] + blca_pkg::node_t'(1);
			end
			if (tree_dep[i] > tree_dep[deep])
				deep = blca_pkg::node_t'(i);
			order[i] = blca_pkg::node_t'(i);
		end
		for (int i = NODES - 1; i > 1; i--) begin
			k = $urandom_range(i, 1);
			tmp = order[i];
			order[i] = order[k];
			order[k] = tmp;
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// every node is loaded before the first build
		for (int i = 1; i < NODES; i++) begin
			if (i == 500)
				send(blca_pkg::KIND_LOAD, '0, rand_node(), rand_node(), rand_node());
			send(blca_pkg::KIND_LOAD, order[i], rand_node(), tree_par[order[i]],
				tree_dep[order[i]]);
		end
		send_build();

		send(blca_pkg::KIND_LCA,  '0, '0, '0, '0);
		send(blca_pkg::KIND_LIFT, '0, '0, '1, '1);
		send(blca_pkg::KIND_LCA,  deep, deep, '1, '1);
		send(blca_pkg::KIND_LIFT, deep, 10'd1, '0, '0);
		send(blca_pkg::KIND_LIFT, deep, '0, '0, '0);
		send(blca_pkg::KIND_LIFT, 10'd1, deep, '0, '0);
		send(blca_pkg::KIND_LCA,  deep, tree_par[deep], '0, '0);
		send(blca_pkg::KIND_LCA,  deep, 10'd1023, '0, '0);
		send(blca_pkg::KIND_LCA,  10'd1023, 10'd1, '0, '0);
		send(blca_pkg::KIND_LIFT, 10'd1023, deep, '0, '0);
		send(blca_pkg::KIND_LCA,  deep, '0, '0, '0);
		// load of the sentinel must be ignored
		send(blca_pkg::KIND_LOAD, '0, '1, '1, '1);
		send(blca_pkg::KIND_LCA,  '0, deep, '0, '0);
		send(blca_pkg::KIND_LIFT, deep, '0, '0, '0);
		send(blca_pkg::KIND_LIFT, '0, deep, '0, '0);
		r = walk_up(deep, tree_dep[deep] / 2);
		send(blca_pkg::KIND_LCA,  deep, r, '0, '0);
		send(blca_pkg::KIND_LIFT, deep, r, '0, '0);
		send(blca_pkg::KIND_LIFT, deep, walk_up(deep, 1), '0, '0);
		send_queries(90);
		drain();

		tx_pct = 74;
		rx_pct = 23;
		reparent(60);
		// queries against a table that is now out of date
		send_queries(15);
		send_build();
		send_queries(90);
		drain();

		tx_pct = 0;
		rx_pct = 0;
		reparent(40);
		send_build();
		send_queries(200);
		// once the build is over, hold answers off so the engine backs up
		while (req_q.size() > 195)
			@(negedge clk);
		holds_asked = holds_asked + 1;
		drain();

		// inconsistent parents and depths
		noise_loads(40);
		send_queries(10);
		send_build();
		repeat (100) begin
			if ($urandom_range(9) == 0)
				noise_loads(1);
			else
				req_q = {req_q, random_query()};
		end
		drain();
		repeat (150) @(negedge clk);

		if (mismatches == 0 && answer_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/blca_pkg.sv
rtl/core/blca_ifs.sv
rtl/core/blca_ctrl.sv
rtl/core/blca_datapath.sv
rtl/core/binary_lifting_lca.sv
rtl/core/blca_checker.sv
sim/binary_lifting_lca_tb.sv
